@@ hdl/hbrt_pkg.sv @@
// Shared types, codes and bitmap helpers for the bitmap radix table.
`default_nettype none
package hbrt_pkg;

   localparam int DIGIT_BITS = 4;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 13;
   localparam int BRANCH_BITS = 5;
   localparam int FANOUT = 16;

   // request codes
   localparam logic [2:0] REQ_LOOKUP = 3'd0;
   localparam logic [2:0] REQ_INSERT = 3'd1;
   localparam logic [2:0] REQ_WRITE  = 3'd2;
   localparam logic [2:0] REQ_ERASE  = 3'd3;
   localparam logic [2:0] REQ_NEXT   = 3'd4;
   localparam logic [2:0] REQ_PREV   = 3'd5;

   // configuration register indexes
   localparam logic [1:0] CSR_LEVELS    = 2'd0;
   localparam logic [1:0] CSR_BRANCH_L0 = 2'd1;
   localparam logic [1:0] CSR_BRANCH_L1 = 2'd2;
   localparam logic [1:0] CSR_BRANCH_L2 = 2'd3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef logic [DIGIT_BITS-1:0] digit_type;
   typedef logic [FANOUT-1:0]     map_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [2:0]            op;
      digit_type [2:0]       key;
      digit_type [2:0]       bmax;
      logic [1:0]            levels;
      logic                  step_miss;
      logic [VALUE_BITS-1:0] wdata;
   } job_type;

   typedef struct packed {
      logic                  found;
      logic                  was_present;
      digit_type [2:0]       key;
      logic [VALUE_BITS-1:0] value;
      logic [COUNT_BITS-1:0] count;
   } result_type;

   // bits 0..top set
   function automatic map_type span_mask(digit_type top);
      logic [FANOUT:0] t;
      t = ({{FANOUT{1'b0}}, 1'b1} << (top + 5'd1)) - {{FANOUT{1'b0}}, 1'b1};
      return t[FANOUT-1:0];
   endfunction

   // lowest set bit: {hit, index}
   function automatic logic [DIGIT_BITS:0] first_up(map_type m);
      logic [DIGIT_BITS:0] r;
      r = '0;
      for (int i = FANOUT - 1; i >= 0; i--) begin
         if (m[i]) r = {1'b1, DIGIT_BITS'(i)};
      end
      return r;
   endfunction

   // highest set bit: {hit, index}
   function automatic logic [DIGIT_BITS:0] first_down(map_type m);
      logic [DIGIT_BITS:0] r;
      r = '0;
      for (int i = 0; i < FANOUT; i++) begin
         if (m[i]) r = {1'b1, DIGIT_BITS'(i)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hdl/hierarchical_bitmap_radix_table.sv @@
// Top level of the hierarchical bitmap radix table.
// Lookup, insert, write and erase read the memories once and then evaluate; finds may
// go on to further leaf and value memory reads on the descent.
// The back end sequencer takes a new request only once the last result is queued.
// Reset (synchronous, active high) clears top and middle bitmaps, leaf valid bits, count and queues,
// restores 3 levels of 16 branches; the value memory is not cleared.
`default_nettype none
module hierarchical_bitmap_radix_table (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [2:0]                       req_type,
   input  wire logic [hbrt_pkg::DIGIT_BITS-1:0]  req_key_digit_l0,
   input  wire logic [hbrt_pkg::DIGIT_BITS-1:0]  req_key_digit_l1,
   input  wire logic [hbrt_pkg::DIGIT_BITS-1:0]  req_key_digit_l2,
   input  wire logic                             req_inclusive,
   input  wire logic [hbrt_pkg::VALUE_BITS-1:0]  req_write_value,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic                                  rsp_found,
   output logic                                  rsp_was_present,
   output logic [hbrt_pkg::DIGIT_BITS-1:0]       rsp_result_digit_l0,
   output logic [hbrt_pkg::DIGIT_BITS-1:0]       rsp_result_digit_l1,
   output logic [hbrt_pkg::DIGIT_BITS-1:0]       rsp_result_digit_l2,
   output logic [hbrt_pkg::VALUE_BITS-1:0]       rsp_read_value,
   output logic [hbrt_pkg::COUNT_BITS-1:0]       rsp_entry_count,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [hbrt_pkg::BRANCH_BITS-1:0] csr_data
);
   import hbrt_pkg::*;

   logic       job_valid, job_take;
   job_type    job;
   result_type head;

   hbrt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_type         (req_type),
      .req_key_digit_l0 (req_key_digit_l0),
      .req_key_digit_l1 (req_key_digit_l1),
      .req_key_digit_l2 (req_key_digit_l2),
      .req_inclusive    (req_inclusive),
      .req_write_value  (req_write_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .job_valid        (job_valid),
      .job              (job),
      .job_take         (job_take)
   );

   hbrt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_head  (head)
   );

   // split the head result into its ports
   assign rsp_found           = head.found;
   assign rsp_was_present     = head.was_present;
   assign rsp_result_digit_l0 = head.key[0];
   assign rsp_result_digit_l1 = head.key[1];
   assign rsp_result_digit_l2 = head.key[2];
   assign rsp_read_value      = head.value;
   assign rsp_entry_count     = head.count;

endmodule
`default_nettype wire

@@ hdl/hbrt_front.sv @@
// Front end: config registers, key clamping, exclusive stepping, job queue.
`default_nettype none
module hbrt_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [2:0]                    req_type,
   input  wire hbrt_pkg::digit_type           req_key_digit_l0,
   input  wire hbrt_pkg::digit_type           req_key_digit_l1,
   input  wire hbrt_pkg::digit_type           req_key_digit_l2,
   input  wire logic                          req_inclusive,
   input  wire logic [hbrt_pkg::VALUE_BITS-1:0] req_write_value,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [hbrt_pkg::BRANCH_BITS-1:0] csr_data,
   output logic                               job_valid,
   output hbrt_pkg::job_type                  job,
   input  wire logic                          job_take
);
   import hbrt_pkg::*;

   logic [1:0]             levels_ff, levels_in;
   logic [BRANCH_BITS-1:0] branch_ff [3];
   logic [BRANCH_BITS-1:0] branch_in [3];

   logic [1:0]      levels;
   digit_type [2:0] bmax;
   digit_type [2:0] raw;
   digit_type [2:0] k;
   digit_type [2:0] stepped;
   logic            carry;
   logic            fwd;
   logic            do_step;
   job_type         job_new;

   job_type    q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;

   // configuration writes
   assign csr_ready = 1'b1;
   always_comb begin
      levels_in = levels_ff;
      for (int i = 0; i < 3; i++) branch_in[i] = branch_ff[i];
      if (csr_valid) begin
         case (csr_index)
            CSR_LEVELS:    levels_in    = csr_data[1:0];
            CSR_BRANCH_L0: branch_in[0] = csr_data;
            CSR_BRANCH_L1: branch_in[1] = csr_data;
            CSR_BRANCH_L2: branch_in[2] = csr_data;
            default:       levels_in    = levels_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= 2'd3;
         for (int i = 0; i < 3; i++) branch_ff[i] <= BRANCH_BITS'(FANOUT);
      end else begin
         levels_ff <= levels_in;
         for (int i = 0; i < 3; i++) branch_ff[i] <= branch_in[i];
      end
   end

   // classify: clamp digits, step exclusive finds
   always_comb begin
      levels = (levels_ff == 2'd0) ? 2'd1 : levels_ff;
      raw = {req_key_digit_l2, req_key_digit_l1, req_key_digit_l0};
      for (int i = 0; i < 3; i++) begin
         if (branch_ff[i] < BRANCH_BITS'(2)) bmax[i] = digit_type'(1);
         else if (branch_ff[i] > BRANCH_BITS'(FANOUT)) bmax[i] = digit_type'(FANOUT - 1);
         else bmax[i] = DIGIT_BITS'(branch_ff[i] - BRANCH_BITS'(1));
         if (i >= int'(levels)) k[i] = '0;
         else if (raw[i] > bmax[i]) k[i] = bmax[i];
         else k[i] = raw[i];
      end
      fwd = (req_type == REQ_NEXT);
      stepped = k;
      carry = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (carry && i < int'(levels)) begin
            if (fwd) begin
               if (stepped[i] < bmax[i]) begin
                  stepped[i] = stepped[i] + digit_type'(1);
                  carry = 1'b0;
               end else begin
                  stepped[i] = '0;
               end
            end else begin
               if (stepped[i] != '0) begin
                  stepped[i] = stepped[i] - digit_type'(1);
                  carry = 1'b0;
               end else begin
                  stepped[i] = bmax[i];
               end
            end
         end
      end
      do_step = (req_type == REQ_NEXT || req_type == REQ_PREV) && !req_inclusive;
      job_new.op        = req_type;
      job_new.key       = do_step ? stepped : k;
      job_new.bmax      = bmax;
      job_new.levels    = levels;
      job_new.step_miss = do_step && carry;
      job_new.wdata     = req_write_value;
   end

   // two-entry job queue
   assign req_full  = (cnt_ff == 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ff];
   assign push_ok   = req_push && !req_full;

   always_comb begin
      wr_in  = push_ok ? ~wr_ff : wr_ff;
      rd_in  = job_take ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, job_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) q_ff[wr_ff] <= job_new;
   end

endmodule
`default_nettype wire

@@ hdl/hbrt_back.sv @@
// Back end: bitmap and value memories, request sequencer, result queue.
`default_nettype none
module hbrt_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 job_valid,
   input  wire hbrt_pkg::job_type    job,
   output logic                      job_take,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output hbrt_pkg::result_type      rsp_head
);
   import hbrt_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD   = 4'd1;
   localparam logic [3:0] ST_EVAL = 4'd2;
   localparam logic [3:0] ST_MID  = 4'd3;
   localparam logic [3:0] ST_LRD  = 4'd4;
   localparam logic [3:0] ST_LEAF = 4'd5;
   localparam logic [3:0] ST_VRD  = 4'd6;
   localparam logic [3:0] ST_VAL  = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   logic [3:0]            state_ff, state_in;
   job_type               job_ff;
   digit_type [2:0]       key_ff, key_in;
   logic                  found_ff, found_in, was_ff, was_in;
   logic [VALUE_BITS-1:0] rv_ff, rv_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   map_type               top_ff, top_in;
   map_type               mid_ff [FANOUT];

   map_type               leaf_mem [FANOUT*FANOUT];
   logic [FANOUT*FANOUT-1:0] leaf_vld_ff;
   map_type               leaf_q_ff;
   logic                  leaf_qv_ff;
   logic [VALUE_BITS-1:0] val_mem [FANOUT*FANOUT*FANOUT];
   logic [VALUE_BITS-1:0] val_q_ff;

   logic [2*DIGIT_BITS-1:0] leaf_addr;
   logic [3*DIGIT_BITS-1:0] val_addr;
   logic                  leaf_we, val_we, mid_we;
   map_type               leaf_wd, mid_wd;
   logic [VALUE_BITS-1:0] val_wd;

   map_type             leaf_word, mid_word;
   map_type             m [3];
   logic [2:0]          act, hit;
   logic [DIGIT_BITS:0] cand [3];
   logic [DIGIT_BITS:0] scan_mid, scan_leaf;
   logic [1:0]          d, f;
   logic                f_ok, exact, present, fwd;
   digit_type [2:0]     miss_key;
   map_type             leaf_cleared, mid_cleared;

   result_type oq_ff [2];
   logic       oq_wr_ff, oq_rd_ff;
   logic [1:0] oq_cnt_ff;
   logic       oq_push, oq_pop, oq_full;

   assign leaf_addr = {key_ff[2], key_ff[1]};
   assign val_addr  = {key_ff[2], key_ff[1], key_ff[0]};

   // examine the words read for the current key
   always_comb begin
      fwd       = (job_ff.op == REQ_NEXT);
      leaf_word = leaf_qv_ff ? leaf_q_ff : '0;
      mid_word  = mid_ff[key_ff[2]];
      m[0] = leaf_word & span_mask(job_ff.bmax[0]);
      m[1] = mid_word  & span_mask(job_ff.bmax[1]);
      m[2] = top_ff    & span_mask(job_ff.bmax[2]);
      for (int i = 0; i < 3; i++) begin
         act[i]  = (i < int'(job_ff.levels));
         hit[i]  = m[i][key_ff[i]];
         cand[i] = fwd ? first_up(m[i] & ~span_mask(key_ff[i]))
                       : first_down(m[i] & (span_mask(key_ff[i]) >> 1));
         miss_key[i] = (!fwd && act[i]) ? job_ff.bmax[i] : '0;
      end
      d = 2'd0;
      if (act[1] && !hit[1]) d = 2'd1;
      if (act[2] && !hit[2]) d = 2'd2;
      exact = (!act[2] || hit[2]) && (!act[1] || hit[1]) && hit[0];
      f_ok = 1'b0;
      f    = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (!f_ok && i >= int'(d) && act[i] && cand[i][DIGIT_BITS]) begin
            f_ok = 1'b1;
            f    = 2'(i);
         end
      end
      present = leaf_word[key_ff[0]] && (!act[1] || mid_word[key_ff[1]])
                && (!act[2] || top_ff[key_ff[2]]);
      scan_mid  = fwd ? first_up(m[1]) : first_down(m[1]);
      scan_leaf = fwd ? first_up(m[0]) : first_down(m[0]);
      leaf_cleared = leaf_word & ~map_type'(16'd1 << key_ff[0]);
      mid_cleared  = mid_word  & ~map_type'(16'd1 << key_ff[1]);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      found_in = found_ff;
      was_in   = was_ff;
      rv_in    = rv_ff;
      count_in = count_ff;
      top_in   = top_ff;
      mid_we   = 1'b0;
      mid_wd   = mid_word;
      leaf_we  = 1'b0;
      leaf_wd  = leaf_word;
      val_we   = 1'b0;
      val_wd   = job_ff.wdata;
      job_take = 1'b0;
      oq_push  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               key_in   = job.key;
               found_in = 1'b0;
               was_in   = 1'b0;
               rv_in    = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: state_in = ST_EVAL;
         ST_EVAL: begin
            state_in = ST_OUT;
            case (job_ff.op)
               REQ_LOOKUP: begin
                  if (present) begin
                     found_in = 1'b1;
                     rv_in    = val_q_ff;
                  end
               end
               REQ_WRITE: begin
                  if (present) begin
                     found_in = 1'b1;
                     val_we   = 1'b1;
                     rv_in    = job_ff.wdata;
                  end
               end
               REQ_INSERT: begin
                  found_in = 1'b1;
                  if (act[1]) begin
                     mid_we = 1'b1;
                     mid_wd = mid_word | map_type'(16'd1 << key_ff[1]);
                  end
                  if (act[2]) top_in = top_ff | map_type'(16'd1 << key_ff[2]);
                  if (leaf_word[key_ff[0]]) begin
                     was_in = 1'b1;
                     rv_in  = val_q_ff;
                  end else begin
                     leaf_we = 1'b1;
                     leaf_wd = leaf_word | map_type'(16'd1 << key_ff[0]);
                     val_we  = 1'b1;
                     val_wd  = '0;
                     rv_in   = '0;
                     if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_BITS'(1);
                  end
               end
               REQ_ERASE: begin
                  if (present) begin
                     found_in = 1'b1;
                     rv_in    = val_q_ff;
                     if (count_ff != '0) count_in = count_ff - COUNT_BITS'(1);
                     leaf_we = 1'b1;
                     leaf_wd = leaf_cleared;
                     if (leaf_cleared == '0 && act[1]) begin
                        mid_we = 1'b1;
                        mid_wd = mid_cleared;
                        if (mid_cleared == '0 && act[2])
                           top_in = top_ff & ~map_type'(16'd1 << key_ff[2]);
                     end
                  end
               end
               REQ_NEXT, REQ_PREV: begin
                  if (job_ff.step_miss || (!exact && !f_ok)) begin
                     key_in = miss_key;
                  end else if (exact) begin
                     found_in = 1'b1;
                     rv_in    = val_q_ff;
                  end else begin
                     key_in[f] = cand[f][DIGIT_BITS-1:0];
                     case (f)
                        2'd0:    state_in = ST_VRD;
                        2'd1:    state_in = ST_LRD;
                        default: state_in = ST_MID;
                     endcase
                  end
               end
               default: found_in = 1'b0;
            endcase
         end
         // descend into the middle node chosen above
         ST_MID: begin
            if (scan_mid[DIGIT_BITS]) begin
               key_in[1] = scan_mid[DIGIT_BITS-1:0];
               state_in  = ST_LRD;
            end else begin
               key_in   = miss_key;
               state_in = ST_OUT;
            end
         end
         ST_LRD: state_in = ST_LEAF;
         ST_LEAF: begin
            if (scan_leaf[DIGIT_BITS]) begin
               key_in[0] = scan_leaf[DIGIT_BITS-1:0];
               state_in  = ST_VRD;
            end else begin
               key_in   = miss_key;
               state_in = ST_OUT;
            end
         end
         ST_VRD: state_in = ST_VAL;
         ST_VAL: begin
            found_in = 1'b1;
            rv_in    = val_q_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!oq_full) begin
               oq_push  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         top_ff   <= '0;
         for (int i = 0; i < FANOUT; i++) mid_ff[i] <= '0;
         leaf_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
         if (mid_we) mid_ff[key_ff[2]] <= mid_wd;
         if (leaf_we) leaf_vld_ff[leaf_addr] <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (job_take) job_ff <= job;
      key_ff     <= key_in;
      found_ff   <= found_in;
      was_ff     <= was_in;
      rv_ff      <= rv_in;
      leaf_qv_ff <= leaf_vld_ff[leaf_addr];
   end

   // leaf bitmap memory
   always_ff @(posedge clock) begin
      if (leaf_we) leaf_mem[leaf_addr] <= leaf_wd;
      leaf_q_ff <= leaf_mem[leaf_addr];
   end

   // value memory
   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_addr] <= val_wd;
      val_q_ff <= val_mem[val_addr];
   end

   // two-entry result queue
   assign oq_full   = (oq_cnt_ff == 2'd2);
   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign rsp_head  = oq_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         if (oq_push) oq_wr_ff <= ~oq_wr_ff;
         if (oq_pop) oq_rd_ff <= ~oq_rd_ff;
         oq_cnt_ff <= oq_cnt_ff + {1'b0, oq_push} - {1'b0, oq_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) oq_ff[oq_wr_ff] <= '{found_ff, was_ff, key_ff, rv_ff, count_ff};
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(4096))
      else $error("entry count beyond table size");
   a_count_eval_only: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_EVAL |=> $stable(count_ff))
      else $error("entry count moved outside evaluation");
   a_insert_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && job_ff.op == REQ_INSERT) |=> found_ff)
      else $error("insert did not report found");
`endif

endmodule
`default_nettype wire
